[design/dgr_pkg.sv]
// Shared types, constants and helpers for the deadlock graph reduction block.
// No dependencies; every other design file imports this package.
package dgr_pkg;

  localparam int T_W       = 4;
  localparam int R_W       = 4;
  localparam int MAX_T     = 1 << T_W;
  localparam int MAX_R     = 1 << R_W;
  localparam int CNT_W     = T_W + 1;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_TCOUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RCOUNT = CFG_IDX_W'(1);

  typedef logic [MAX_R-1:0] row_t;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_HOLD  = 2'd1,
    ACT_WAIT  = 2'd2,
    ACT_STEP  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    OP_SCAN,
    OP_RELEASE,
    OP_GRANT,
    OP_ADD_HOLD,
    OP_ADD_WAIT,
    OP_CLEAR
  } row_op_e;

  typedef struct packed {
    row_op_e        op;
    logic           in_use;
    logic           add_en;
    logic [R_W-1:0] res_idx;
  } alu_ctl_t;

  typedef struct packed {
    row_t new_hold;
    row_t new_wait;
    row_t held_bits;
    row_t claim_bits;
    logic changed;
    logic live;
    logic conflict;
  } alu_res_t;

  // 0 reads as 1, anything above the maximum saturates
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DAT_W-1:0] v,
                                                   input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (CNT_W'(v) > maxv) begin
      r = maxv;
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  function automatic row_t col_mask(input logic [CNT_W-1:0] rc);
    row_t m;
    for (int r = 0; r < MAX_R; r++) begin
      m[r] = (CNT_W'(r) < rc);
    end
    return m;
  endfunction

endpackage

[design/dgr_graph.sv]
// Hold and wait matrix storage: one row read and one row written per cycle.
// Depends on dgr_pkg.
module dgr_graph import dgr_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [T_W-1:0] addr_i,
  input  logic           wr_en_i,
  input  row_t           wr_hold_i,
  input  row_t           wr_wait_i,
  output row_t           rd_hold_o,
  output row_t           rd_wait_o
);

  row_t hold_q [MAX_T];
  row_t wait_q [MAX_T];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < MAX_T; t++) begin
        hold_q[t] <= '0;
        wait_q[t] <= '0;
      end
    end else if (wr_en_i) begin
      hold_q[addr_i] <= wr_hold_i;
      wait_q[addr_i] <= wr_wait_i;
    end
  end

  assign rd_hold_o = hold_q[addr_i];
  assign rd_wait_o = wait_q[addr_i];

endmodule

[design/dgr_row_alu.sv]
// Shared row unit: updates one transaction row per cycle for every sweep.
// Depends on dgr_pkg.
module dgr_row_alu import dgr_pkg::*; (
  input  alu_ctl_t ctl_i,
  input  row_t     hold_i,
  input  row_t     wait_i,
  input  row_t     mask_i,
  input  row_t     held_i,
  input  row_t     claimed_i,
  output alu_res_t res_o
);

  row_t hm;
  row_t grant;
  row_t bit_sel;

  always_comb begin
    hm       = hold_i & mask_i;
    grant    = '0;
    bit_sel  = row_t'(1) << ctl_i.res_idx;
    res_o    = '0;
    res_o.new_hold = hold_i;
    res_o.new_wait = wait_i;
    unique case (ctl_i.op)
      OP_CLEAR: begin
        res_o.new_hold = '0;
        res_o.new_wait = '0;
      end
      OP_RELEASE: begin
        // a transaction waiting for nothing gives back everything it holds
        if (ctl_i.in_use && (|hm) && !(|(wait_i & mask_i))) begin
          res_o.new_hold = hold_i & ~mask_i;
          res_o.changed  = 1'b1;
        end
      end
      OP_GRANT: begin
        // free resources go to the lowest waiter not yet passed
        if (ctl_i.in_use) begin
          grant          = wait_i & mask_i & ~held_i & ~claimed_i;
          res_o.new_hold = hold_i | grant;
          res_o.new_wait = wait_i & ~grant;
          res_o.changed  = |grant;
        end
      end
      OP_ADD_HOLD: begin
        if (ctl_i.add_en) res_o.new_hold = hold_i | bit_sel;
      end
      OP_ADD_WAIT: begin
        if (ctl_i.add_en) res_o.new_wait = wait_i | bit_sel;
      end
      OP_SCAN: begin
      end
      default: begin
      end
    endcase
    res_o.held_bits  = ctl_i.in_use ? (res_o.new_hold & mask_i) : '0;
    res_o.claim_bits = ctl_i.in_use ? (wait_i & mask_i) : '0;
    res_o.live       = ctl_i.in_use && (|(res_o.new_hold & mask_i));
    res_o.conflict   = hold_i[ctl_i.res_idx];
  end

endmodule

[design/deadlock_graph_reduction.sv]
// Top level: command port, count registers and sweep sequencer.
// Depends on dgr_pkg, dgr_graph, dgr_row_alu.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+----------------------------------------
//  command  | start (in), busy (out)       | action_i, transaction_index_i, resource_index_i
//  result   | done_o (one-cycle strobe)    | changed_o, deadlock_o, refused_o
//  config   | cfg_valid_i, cfg_ready_o     | cfg_index_i, cfg_data_i
//
// Every item walks the 16 transaction rows through one row unit, one row per clock.
// Clear: a full sweep. Add hold/wait: a 16-row scan, then an update of the addressed row.
// Reduction step: a release sweep, then a grant sweep.
// The result strobe is registered in the final state; busy falls together with it.
// Reset clears both matrices and sets both counts to 1. Results cannot be stalled.
module deadlock_graph_reduction import dgr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           action_i,
  input  logic [T_W-1:0]       transaction_index_i,
  input  logic [R_W-1:0]       resource_index_i,
  output logic                 done_o,
  output logic                 changed_o,
  output logic                 deadlock_o,
  output logic                 refused_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN,
    S_APPLY,
    S_RELEASE,
    S_GRANT
  } state_e;

  state_e           state_q;
  logic             busy_q;
  logic [T_W-1:0]   t_q;
  action_e          act_q;
  logic [T_W-1:0]   ti_q;
  logic [R_W-1:0]   ri_q;
  row_t             held_q, held_d;
  row_t             claimed_q, claimed_d;
  logic             chg_q, chg_d;
  logic             dl_q, dl_d;
  logic             conflict_q, conflict_d;
  logic             done_q, changed_q, deadlock_q, refused_q;
  logic [CNT_W-1:0] tcount_q, rcount_q;

  logic [T_W-1:0]   addr;
  logic             wr_en;
  logic             last_row;
  logic             out_of_range;
  row_t             mask;
  row_t             rd_hold, rd_wait;
  alu_ctl_t         ctl;
  alu_res_t         res;

  assign busy        = busy_q;
  assign cfg_ready_o = ~busy_q;
  assign done_o      = done_q;
  assign changed_o   = changed_q;
  assign deadlock_o  = deadlock_q;
  assign refused_o   = refused_q;

  // configuration counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcount_q <= CNT_W'(1);
      rcount_q <= CNT_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_TCOUNT) tcount_q <= clamp_count(cfg_data_i, CNT_W'(MAX_T));
      if (cfg_index_i == REG_RCOUNT) rcount_q <= clamp_count(cfg_data_i, CNT_W'(MAX_R));
    end
  end

  assign mask         = col_mask(rcount_q);
  assign addr         = (state_q == S_APPLY) ? ti_q : t_q;
  assign last_row     = (t_q == T_W'(MAX_T - 1));
  assign out_of_range = ({1'b0, ti_q} >= tcount_q) || ({1'b0, ri_q} >= rcount_q);

  always_comb begin
    ctl         = '0;
    ctl.in_use  = ({1'b0, addr} < tcount_q);
    ctl.res_idx = ri_q;
    ctl.add_en  = !out_of_range && !((act_q == ACT_HOLD) && conflict_q);
    wr_en       = 1'b1;
    unique case (state_q)
      S_CLEAR:   ctl.op = OP_CLEAR;
      S_RELEASE: ctl.op = OP_RELEASE;
      S_GRANT:   ctl.op = OP_GRANT;
      S_APPLY:   ctl.op = (act_q == ACT_HOLD) ? OP_ADD_HOLD : OP_ADD_WAIT;
      S_SCAN: begin
        ctl.op = OP_SCAN;
        wr_en  = 1'b0;
      end
      default: begin
        ctl.op = OP_SCAN;
        wr_en  = 1'b0;
      end
    endcase
  end

  dgr_graph u_graph (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .addr_i    (addr),
    .wr_en_i   (wr_en),
    .wr_hold_i (res.new_hold),
    .wr_wait_i (res.new_wait),
    .rd_hold_o (rd_hold),
    .rd_wait_o (rd_wait)
  );

  dgr_row_alu u_alu (
    .ctl_i     (ctl),
    .hold_i    (rd_hold),
    .wait_i    (rd_wait),
    .mask_i    (mask),
    .held_i    (held_q),
    .claimed_i (claimed_q),
    .res_o     (res)
  );

  // sweep accumulators including the current row
  assign held_d     = held_q | res.held_bits;
  assign claimed_d  = claimed_q | res.claim_bits;
  assign chg_d      = chg_q | res.changed;
  assign dl_d       = dl_q | res.live;
  assign conflict_d = conflict_q | res.conflict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      busy_q     <= 1'b0;
      t_q        <= '0;
      act_q      <= ACT_CLEAR;
      ti_q       <= '0;
      ri_q       <= '0;
      held_q     <= '0;
      claimed_q  <= '0;
      chg_q      <= 1'b0;
      dl_q       <= 1'b0;
      conflict_q <= 1'b0;
      done_q     <= 1'b0;
      changed_q  <= 1'b0;
      deadlock_q <= 1'b0;
      refused_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            act_q      <= action_e'(action_i);
            ti_q       <= transaction_index_i;
            ri_q       <= resource_index_i;
            t_q        <= '0;
            held_q     <= '0;
            claimed_q  <= '0;
            chg_q      <= 1'b0;
            dl_q       <= 1'b0;
            conflict_q <= 1'b0;
            busy_q     <= 1'b1;
            unique case (action_e'(action_i))
              ACT_CLEAR: state_q <= S_CLEAR;
              ACT_STEP:  state_q <= S_RELEASE;
              default:   state_q <= S_SCAN;
            endcase
          end
        end
        S_CLEAR: begin
          t_q <= t_q + T_W'(1);
          if (last_row) begin
            state_q    <= S_IDLE;
            busy_q     <= 1'b0;
            done_q     <= 1'b1;
            changed_q  <= 1'b0;
            deadlock_q <= 1'b0;
            refused_q  <= 1'b0;
          end
        end
        S_SCAN: begin
          t_q        <= t_q + T_W'(1);
          dl_q       <= dl_d;
          conflict_q <= conflict_d;
          if (last_row) state_q <= S_APPLY;
        end
        S_APPLY: begin
          state_q    <= S_IDLE;
          busy_q     <= 1'b0;
          done_q     <= 1'b1;
          changed_q  <= 1'b0;
          refused_q  <= ~ctl.add_en;
          // an accepted hold is in range, so it always leaves a live hold
          deadlock_q <= dl_q | ((act_q == ACT_HOLD) && ctl.add_en);
        end
        S_RELEASE: begin
          t_q    <= t_q + T_W'(1);
          held_q <= held_d;
          chg_q  <= chg_d;
          if (last_row) state_q <= S_GRANT;
        end
        S_GRANT: begin
          t_q       <= t_q + T_W'(1);
          claimed_q <= claimed_d;
          chg_q     <= chg_d;
          dl_q      <= dl_d;
          if (last_row) begin
            state_q    <= S_IDLE;
            busy_q     <= 1'b0;
            done_q     <= 1'b1;
            changed_q  <= chg_d;
            deadlock_q <= dl_d;
            refused_q  <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) == !busy_q)
    else $error("busy flag out of step with sequencer");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("result strobe while a request is still in work");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a sweep");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("more than one result for a request");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !(changed_q && refused_q))
    else $error("changed and refused both set");
`endif

endmodule

[tb/deadlock_graph_reduction_tb.sv]
// Self-checking testbench for deadlock_graph_reduction: hold/wait arc requests and
// reduction steps are checked against an in-bench model of the graph. Depends on dgr_pkg.
module deadlock_graph_reduction_tb;
  import dgr_pkg::*;

  localparam int IDLE_LIMIT      = 4000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int TARGET_REQUESTS = 1150;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct packed {
    logic changed;
    logic deadlock;
    logic refused;
  } outcome_t;

  logic                 clk_i               = 1'b0;
  logic                 rst_ni              = 1'b0;
  logic                 start               = 1'b0;
  logic                 busy;
  logic [1:0]           action_i            = '0;
  logic [T_W-1:0]       transaction_index_i = '0;
  logic [R_W-1:0]       resource_index_i    = '0;
  logic                 done_o;
  logic                 changed_o;
  logic                 deadlock_o;
  logic                 refused_o;
  logic                 cfg_valid_i         = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i         = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i          = '0;

  always #5 clk_i = ~clk_i;

  deadlock_graph_reduction dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .action_i            (action_i),
    .transaction_index_i (transaction_index_i),
    .resource_index_i    (resource_index_i),
    .done_o              (done_o),
    .changed_o           (changed_o),
    .deadlock_o          (deadlock_o),
    .refused_o           (refused_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  // graph model
  row_t             hold_rows [MAX_T];
  row_t             wait_rows [MAX_T];
  logic [CNT_W-1:0] txn_count;
  logic [CNT_W-1:0] res_count;
  outcome_t         outcome_q [$];

  int   mismatches    = 0;
  int   requests_sent = 0;
  int   idle_cycles   = 0;
  logic no_gaps       = 1'b0;

  function automatic logic [CNT_W-1:0] count_from_data(logic [CFG_DAT_W-1:0] v, int limit);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > limit) return CNT_W'(limit);
    return CNT_W'(v);
  endfunction

  function automatic row_t live_columns();
    row_t m;
    for (int r = 0; r < MAX_R; r++) m[r] = (r < int'(res_count));
    return m;
  endfunction

  function automatic logic reduce_graph();
    row_t m;
    logic moved;
    logic held;
    int   first;
    m     = live_columns();
    moved = 1'b0;
    // release phase: holders that wait for nothing give everything back
    for (int t = 0; t < int'(txn_count); t++) begin
      if ((hold_rows[t] & m) != '0 && (wait_rows[t] & m) == '0) begin
        hold_rows[t] &= ~m;
        moved = 1'b1;
      end
    end
    // grant phase: free resources go to the lowest-numbered waiter in use
    for (int r = 0; r < int'(res_count); r++) begin
      held  = 1'b0;
      first = -1;
      for (int t = 0; t < int'(txn_count); t++) begin
        if (hold_rows[t][r]) held = 1'b1;
        if (first < 0 && wait_rows[t][r]) first = t;
      end
      if (first >= 0 && !held) begin
        hold_rows[first][r] = 1'b1;
        wait_rows[first][r] = 1'b0;
        moved = 1'b1;
      end
    end
    return moved;
  endfunction

  function automatic outcome_t predict_outcome(action_e act, logic [T_W-1:0] ti,
                                               logic [R_W-1:0] ri);
    outcome_t o;
    row_t     m;
    o = '0;
    case (act)
      ACT_CLEAR: begin
        for (int t = 0; t < MAX_T; t++) begin
          hold_rows[t] = '0;
          wait_rows[t] = '0;
        end
      end
      ACT_STEP: o.changed = reduce_graph();
      default: begin
        if (CNT_W'(ti) >= txn_count || CNT_W'(ri) >= res_count) begin
          o.refused = 1'b1;
        end else if (act == ACT_HOLD) begin
          // any stored holder counts, even outside the counts
          for (int t = 0; t < MAX_T; t++) begin
            if (hold_rows[t][ri]) o.refused = 1'b1;
          end
          if (!o.refused) hold_rows[ti][ri] = 1'b1;
        end else begin
          wait_rows[ti][ri] = 1'b1;
        end
      end
    endcase
    m = live_columns();
    for (int t = 0; t < int'(txn_count); t++) begin
      if ((hold_rows[t] & m) != '0) o.deadlock = 1'b1;
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : request_monitor
    if (!rst_ni) begin
      for (int t = 0; t < MAX_T; t++) begin
        hold_rows[t] = '0;
        wait_rows[t] = '0;
      end
      txn_count = CNT_W'(1);
      res_count = CNT_W'(1);
      outcome_q.delete();
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(predict_outcome(action_e'(action_i), transaction_index_i,
                                            resource_index_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_TCOUNT: txn_count = count_from_data(cfg_data_i, MAX_T);
          REG_RCOUNT: res_count = count_from_data(cfg_data_i, MAX_R);
          default: ;
        endcase
      end
    end
  end

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_checker
    outcome_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result strobe with no request pending");
      end else begin
        want = outcome_q.pop_front();
        if (changed_o !== want.changed)
          report_mismatch($sformatf("changed %b, expected %b", changed_o, want.changed));
        if (deadlock_o !== want.deadlock)
          report_mismatch($sformatf("deadlock %b, expected %b", deadlock_o, want.deadlock));
        if (refused_o !== want.refused)
          report_mismatch($sformatf("refused %b, expected %b", refused_o, want.refused));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // start stays high between back-to-back requests; it only drops for a gap
  task automatic send_request(action_e act, logic [T_W-1:0] ti, logic [R_W-1:0] ri);
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (roll < 60) gap = $urandom_range(0, 2);
    else if (roll < 92) gap = $urandom_range(3, 10);
    else gap = $urandom_range(20, 70);
    if (no_gaps) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start               <= 1'b1;
    action_i            <= act;
    transaction_index_i <= ti;
    resource_index_i    <= ri;
    do @(posedge clk_i); while (busy);
    requests_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // counts are 1/1 after reset: one transaction, one resource
  task automatic test_single_slot();
    send_request(ACT_STEP, 4'd0, 4'd0);
    send_request(ACT_HOLD, 4'd0, 4'd0);
    send_request(ACT_HOLD, 4'd0, 4'd0);   // already held by itself
    send_request(ACT_WAIT, 4'd0, 4'd0);   // wait on own hold
    send_request(ACT_WAIT, 4'd0, 4'd0);   // duplicate wait
    send_request(ACT_HOLD, 4'd1, 4'd0);   // transaction out of range
    send_request(ACT_WAIT, 4'd0, 4'd15);  // resource out of range
    send_request(ACT_STEP, 4'd0, 4'd0);
    send_request(ACT_CLEAR, 4'd15, 4'd15);
    settle();
  endtask

  task automatic test_count_registers();
    write_register(REG_TCOUNT, 5'd0);
    write_register(REG_RCOUNT, 5'd31);
    write_register(REG_SPARE_A, CFG_DAT_W'($urandom_range(0, 31)));
    write_register(REG_SPARE_B, CFG_DAT_W'($urandom_range(0, 31)));
    write_register(REG_TCOUNT, 5'd17);
    send_request(ACT_HOLD, 4'd15, 4'd0);
    send_request(ACT_HOLD, 4'd15, 4'd15);
    settle();
    // shrink: arcs of transaction 15 stay stored but drop out of the step
    write_register(REG_TCOUNT, 5'd1);
    write_register(REG_RCOUNT, 5'd1);
    send_request(ACT_HOLD, 4'd0, 4'd0);
    send_request(ACT_WAIT, 4'd0, 4'd0);
    send_request(ACT_STEP, 4'd0, 4'd0);
    settle();
    write_register(REG_TCOUNT, 5'd16);
    write_register(REG_RCOUNT, 5'd16);
    send_request(ACT_STEP, 4'd0, 4'd0);
    send_request(ACT_CLEAR, 4'd0, 4'd0);
    settle();
  endtask

  task automatic test_deadlock_cycle();
    send_request(ACT_HOLD, 4'd0, 4'd0);
    send_request(ACT_HOLD, 4'd1, 4'd1);
    send_request(ACT_WAIT, 4'd0, 4'd1);
    send_request(ACT_WAIT, 4'd1, 4'd0);
    send_request(ACT_STEP, 4'd0, 4'd0);
    send_request(ACT_CLEAR, 4'd0, 4'd0);
    settle();
  endtask

  task automatic test_release_chain();
    send_request(ACT_HOLD, 4'd2, 4'd5);
    send_request(ACT_WAIT, 4'd3, 4'd5);
    send_request(ACT_WAIT, 4'd4, 4'd5);
    repeat (4) send_request(ACT_STEP, 4'd0, 4'd0);
    settle();
  endtask

  task automatic test_random_graphs();
    int phase;
    int tc;
    int rc;
    int tdata;
    int rdata;
    logic [T_W-1:0] ti;
    logic [R_W-1:0] ri;
    phase = 0;
    while (requests_sent < TARGET_REQUESTS) begin
      case (phase)
        0: begin tdata = 1;  rdata = 1;  end
        1: begin tdata = 16; rdata = 16; end
        2: begin tdata = 16; rdata = 1;  end
        3: begin tdata = 1;  rdata = 16; end
        default: begin
          tdata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(1, $urandom_range(2, 16));
          rdata = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(1, $urandom_range(2, 16));
        end
      endcase
      tc = (tdata == 0) ? 1 : (tdata > MAX_T) ? MAX_T : tdata;
      rc = (rdata == 0) ? 1 : (rdata > MAX_R) ? MAX_R : rdata;
      settle();
      write_register(REG_TCOUNT, CFG_DAT_W'(tdata));
      write_register(REG_RCOUNT, CFG_DAT_W'(rdata));
      repeat ($urandom_range(2, 6)) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 85) begin
          // fresh graph, a handful of arcs, then reduce it a few times
          send_request(ACT_CLEAR, T_W'($urandom_range(0, 15)), R_W'($urandom_range(0, 15)));
          repeat ($urandom_range(1, 12)) begin
            ti = ($urandom_range(0, 9) == 0) ? T_W'($urandom_range(0, 15))
                                             : T_W'($urandom_range(0, tc - 1));
            ri = ($urandom_range(0, 9) == 0) ? R_W'($urandom_range(0, 15))
                                             : R_W'($urandom_range(0, rc - 1));
            send_request(action_e'($urandom_range(0, 1) ? ACT_HOLD : ACT_WAIT), ti, ri);
          end
          repeat ($urandom_range(1, 5))
            send_request(ACT_STEP, T_W'($urandom_range(0, 15)), R_W'($urandom_range(0, 15)));
        end else begin
          repeat ($urandom_range(1, 10))
            send_request(action_e'($urandom_range(0, 3)), T_W'($urandom_range(0, 15)),
                         R_W'($urandom_range(0, 15)));
        end
      end
      phase++;
    end
    no_gaps = 1'b0;
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_single_slot();
    test_count_registers();
    test_deadlock_cycle();
    test_release_chain();
    test_random_graphs();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
